FILE: sv/ffa_pkg.sv
// shared types and constants of the first-fit free list allocator
package ffa_pkg;

	localparam int DATA_W  = 32;
	localparam int MIN_W   = 13;
	localparam int PADDR_W = 3;

	localparam logic [MIN_W-1:0] MIN_BLOCK_RESET = 13'd16;
	// word index of the min_block_bytes register (paddr[2])
	localparam logic REG_MIN_BLOCK = 1'b0;

	typedef enum logic [0:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FIT    = 2'd1,
		ST_TOO_SMALL = 2'd2,
		ST_FULL      = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_e;

	// what every cell of the ring does in one cycle
	typedef enum logic [1:0] {
		CHAIN_HOLD,
		CHAIN_PUSH,
		CHAIN_PULL,
		CHAIN_ROTATE
	} chain_op_e;

	typedef struct packed {
		chain_op_e op;
		logic      tail;
	} cell_ctl_t;

	typedef struct packed {
		cmd_e              cmd;
		logic [DATA_W-1:0] req_size;
		logic [DATA_W-1:0] block_addr;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] result_addr;
		status_e           status;
	} resp_t;

endpackage

FILE: sv/ffa_cell.sv
// one entry of the free list ring: base and size, loaded from a neighbor
module ffa_cell
	import ffa_pkg::*;
#(
	parameter int AW = 32
) (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [AW-1:0]     left_base,
	input  logic [DATA_W-1:0] left_size,
	input  logic [AW-1:0]     right_base,
	input  logic [DATA_W-1:0] right_size,
	input  logic [AW-1:0]     wrap_base,
	input  logic [DATA_W-1:0] wrap_size,
	output logic [AW-1:0]     base,
	output logic [DATA_W-1:0] size
);

	logic [AW-1:0]     base_q;
	logic [DATA_W-1:0] size_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CHAIN_HOLD: begin
			end
			CHAIN_PUSH: begin
				base_q <= left_base;
				size_q <= left_size;
			end
			CHAIN_PULL: begin
				base_q <= right_base;
				size_q <= right_size;
			end
			CHAIN_ROTATE: begin
				// the last live cell closes the ring
				if (ctl.tail) begin
					base_q <= wrap_base;
					size_q <= wrap_size;
				end else begin
					base_q <= right_base;
					size_q <= right_size;
				end
			end
			default: begin
			end
		endcase
	end

	assign base = base_q;
	assign size = size_q;

endmodule

FILE: sv/first_fit_free_list_allocator.sv
// first-fit free list allocator: ring of entry cells inspected at cell zero
// free: accepted in idle; the finish state registers the result once the output can take it
// allocate: ring rotates one entry per cycle past cell zero until every entry has passed,
//   then the finish state registers the result once the output can take it
// result sits in an output register, a new request is taken while it waits
// arst_n clears the list count, control state and min_block_bytes (16); entries are not cleared
module first_fit_free_list_allocator
	import ffa_pkg::*;
#(
	parameter int MAX_FREE_BLOCKS = 16,
	parameter int ADDR_BITS       = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req_data,
	// response channel
	output logic               resp_valid,
	input  logic               resp_stall,
	output resp_t              resp_data,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	localparam int N     = MAX_FREE_BLOCKS;
	localparam int AW    = ADDR_BITS;
	localparam int CW    = $clog2(N + 1);
	// width for the tail address sum, wide enough for both operands
	localparam int SUM_W = (AW > DATA_W) ? AW : DATA_W;
	localparam logic [SUM_W-1:0] ADDR_MASK = {SUM_W{1'b1}} >> (SUM_W - AW);
	localparam logic [CW-1:0]    FULL_COUNT = CW'(N);

	// ---------------- register port ----------------
	logic [MIN_W-1:0] min_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_BLOCK_RESET;
		end else if (cfg_wr && paddr[2] == REG_MIN_BLOCK) begin
			min_q <= pwdata[MIN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_MIN_BLOCK) ? {{(DATA_W-MIN_W){1'b0}}, min_q} : '0;

	// ---------------- control state ----------------
	state_e  state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rot_q;      // entries rotated past cell zero so far
	logic          found_q;    // a block was taken during this scan

	// request held for the scan
	logic [DATA_W-1:0] req_size_q;
	logic [DATA_W:0]   need_q;  // request plus the split leftover, 33 bits

	// pending result
	status_e           res_status_q;
	logic [AW-1:0]     res_base_q;
	logic [DATA_W-1:0] res_off_q;
	logic              res_split_q;

	logic resp_valid_q;
	resp_t resp_q;

	// ---------------- cell ring ----------------
	logic [AW-1:0]     base_w [N];
	logic [DATA_W-1:0] size_w [N];
	cell_ctl_t         ctl_w  [N];
	chain_op_e         chain_op;
	logic [DATA_W-1:0] wrap_size;

	logic req_acc;
	logic is_free;
	logic too_small;
	logic list_full;
	logic scan_live;   // cell zero holds an entry not yet looked at
	logic hit_exact;
	logic hit_split;
	logic load_resp;
	logic [DATA_W-1:0] split_size;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid & ~req_stall;
	assign is_free   = (req_data.cmd == CMD_FREE);
	assign too_small = (req_data.req_size < {{(DATA_W-MIN_W){1'b0}}, min_q});
	assign list_full = (count_q == FULL_COUNT);

	// first fit test on the entry now at cell zero; exact match wins over split
	assign scan_live  = (state_q == S_SCAN) && (rot_q != count_q) && !found_q;
	assign hit_exact  = scan_live && (size_w[0] == req_size_q);
	assign hit_split  = scan_live && !hit_exact && ({1'b0, size_w[0]} >= need_q);
	assign split_size = size_w[0] - req_size_q;
	assign wrap_size  = hit_split ? split_size : size_w[0];

	assign load_resp = (state_q == S_FINISH) && (!resp_valid_q || !resp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and ring command
	always_comb begin
		state_d  = state_q;
		chain_op = CHAIN_HOLD;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					if (is_free) begin
						state_d = S_FINISH;
						if (!too_small && !list_full) begin
							chain_op = CHAIN_PUSH;
						end
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				// rotating count entries brings the list back to its order
				if (rot_q == count_q) begin
					state_d = S_FINISH;
				end else if (hit_exact) begin
					chain_op = CHAIN_PULL;
				end else begin
					chain_op = CHAIN_ROTATE;
				end
			end
			S_FINISH: begin
				if (load_resp) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rot_q   <= '0;
			found_q <= 1'b0;
		end else begin
			if (state_q == S_IDLE) begin
				rot_q   <= '0;
				found_q <= 1'b0;
			end else if (chain_op == CHAIN_ROTATE) begin
				rot_q <= rot_q + 1'b1;
			end
			if (hit_exact || hit_split) begin
				found_q <= 1'b1;
			end
			if (chain_op == CHAIN_PUSH) begin
				count_q <= count_q + 1'b1;
			end else if (chain_op == CHAIN_PULL) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// request and pending result payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_size_q  <= req_data.req_size;
			need_q      <= {1'b0, req_data.req_size} +
				{{(DATA_W+1-MIN_W){1'b0}}, min_q};
			res_split_q <= 1'b0;
			if (!is_free) begin
				res_status_q <= ST_NO_FIT;
			end else if (too_small) begin
				res_status_q <= ST_TOO_SMALL;
			end else if (list_full) begin
				res_status_q <= ST_FULL;
			end else begin
				res_status_q <= ST_OK;
			end
		end
		if (hit_exact) begin
			res_status_q <= ST_OK;
			res_base_q   <= base_w[0];
		end
		if (hit_split) begin
			res_status_q <= ST_OK;
			res_base_q   <= base_w[0];
			res_off_q    <= split_size;
			res_split_q  <= 1'b1;
		end
	end

	// result register; a tail address wraps at the address width
	logic [SUM_W-1:0]  tail_sum;
	logic [DATA_W-1:0] res_addr;

	assign tail_sum = (SUM_W'(res_base_q) + SUM_W'(res_off_q)) & ADDR_MASK;

	always_comb begin
		if (!found_q) begin
			res_addr = '0;
		end else if (res_split_q) begin
			res_addr = DATA_W'(tail_sum);
		end else begin
			res_addr = DATA_W'(res_base_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_valid_q <= 1'b0;
		end else if (load_resp) begin
			resp_valid_q <= 1'b1;
		end else if (!resp_stall) begin
			resp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_resp) begin
			resp_q.result_addr <= res_addr;
			resp_q.status      <= res_status_q;
		end
	end

	assign resp_valid = resp_valid_q;
	assign resp_data  = resp_q;

	// ring of cells: push enters at cell zero, pull shifts toward cell zero,
	// rotate sends cell zero (shrunk on a split) to the last live cell
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [AW-1:0]     lb;
		logic [DATA_W-1:0] ls;
		logic [AW-1:0]     rb;
		logic [DATA_W-1:0] rs;

		if (i == 0) begin : g_head
			assign lb = AW'(req_data.block_addr);
			assign ls = req_data.req_size;
		end else begin : g_body
			assign lb = base_w[i-1];
			assign ls = size_w[i-1];
		end

		if (i == N - 1) begin : g_end
			assign rb = base_w[0];
			assign rs = size_w[0];
		end else begin : g_mid
			assign rb = base_w[i+1];
			assign rs = size_w[i+1];
		end

		assign ctl_w[i].op   = chain_op;
		assign ctl_w[i].tail = (count_q == CW'(i + 1));

		ffa_cell #(
			.AW (AW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl_w[i]),
			.left_base  (lb),
			.left_size  (ls),
			.right_base (rb),
			.right_size (rs),
			.wrap_base  (base_w[0]),
			.wrap_size  (wrap_size),
			.base       (base_w[i]),
			.size       (size_w[i])
		);
	end

`ifndef SYNTHESIS
	// list never holds more entries than cells
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("free list count beyond capacity");

	// the scan never rotates past the live part of the ring
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (rot_q <= count_q))
		else $error("scan rotation beyond list length");

	// the list only grows on an accepted free
	assert property (@(posedge clk) disable iff (!arst_n)
		(chain_op == CHAIN_PUSH) |-> (state_q == S_IDLE && req_acc && is_free))
		else $error("push outside an accepted free");

	// a failed request never returns an address
	assert property (@(posedge clk) disable iff (!arst_n)
		(resp_valid && resp_data.status != ST_OK) |-> (resp_data.result_addr == '0))
		else $error("address returned with failure status");
`endif

endmodule

FILE: dv/first_fit_free_list_allocator_test.sv
// self-checking testbench of the first-fit free list allocator: directed table, then random traffic
module first_fit_free_list_allocator_test;
	import ffa_pkg::*;

	localparam int LIST_DEPTH   = 16;
	localparam int ADDR_W       = 32;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 320;
	localparam int RECENT_DEPTH = 32;
	localparam int LONG_HOLD    = 400;
	localparam int REPORT_MAX   = 10;

	// min_block_bytes lives at byte address 4 * its index
	localparam logic [PADDR_W-1:0] MIN_BLOCK_ADDR = {REG_MIN_BLOCK, 2'b00};

	// clock, reset and the block's ports; the inputs driven here are known from time zero
	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              req_valid  = 1'b0;
	logic              req_stall;
	req_t              req_data   = '0;
	logic              resp_valid;
	logic              resp_stall = 1'b0;
	resp_t             resp_data;
	logic              psel       = 1'b0;
	logic              penable    = 1'b0;
	logic              pwrite     = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata     = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	first_fit_free_list_allocator #(
		.MAX_FREE_BLOCKS(LIST_DEPTH),
		.ADDR_BITS      (ADDR_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.resp_valid(resp_valid),
		.resp_stall(resp_stall),
		.resp_data (resp_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #5 clk = ~clk;

	// shadow copy of the free list, head at index 0
	logic [DATA_W-1:0] shadow_base [LIST_DEPTH];
	logic [DATA_W-1:0] shadow_size [LIST_DEPTH];
	int unsigned       shadow_count = 0;
	logic [MIN_W-1:0]  shadow_min   = MIN_BLOCK_RESET;

	// a result typed into the directed table overrides the predicted one
	typedef struct {
		bit    on;
		resp_t resp;
	} pinned_t;

	resp_t   alloc_results_q [$];	// results owed by the block, oldest first
	pinned_t pinned_q        [$];	// one entry per request sent, in order
	int      mismatches = 0;

	// sizes recently put on the list, used to aim allocations at real entries
	logic [DATA_W-1:0] recent_sizes [RECENT_DEPTH];
	int                recent_wr = 0;

	// long receiver hold-off: the sender bumps the ask count, the receiver counts
	int hold_asks = 0;

	typedef enum {
		ROW_REQ,	// send a request reps times, address advancing by step
		ROW_MIN		// write min_block_bytes with the size column
	} row_kind_e;

	typedef struct {
		row_kind_e         kind;
		cmd_e              cmd;
		logic [DATA_W-1:0] size;
		logic [DATA_W-1:0] addr;
		logic [DATA_W-1:0] step;
		int                reps;
		bit                pinned;
		logic [DATA_W-1:0] want_addr;
		status_e           want_status;
	} row_t;

	localparam int DIR_ROWS = 18;

	row_t dir_rows [DIR_ROWS] = '{
		// list is empty after reset, address field ignored on allocate
		'{ROW_REQ, CMD_ALLOC, 32'd16, 32'hDEAD_BEEF, 32'd0, 1, 1'b1, 32'd0, ST_NO_FIT},
		// largest block at the top of the address space
		'{ROW_REQ, CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1, 1'b1, 32'd0, ST_OK},
		// split: tail address wraps past 2^32
		'{ROW_REQ, CMD_ALLOC, 32'd1, 32'd0, 32'd0, 1, 1'b1, 32'hFFFF_FFFD, ST_OK},
		// leftover would need a 33rd bit, not exact either
		'{ROW_REQ, CMD_ALLOC, 32'hFFFF_FFF0, 32'd0, 32'd0, 1, 1'b1, 32'd0, ST_NO_FIT},
		// exact match takes the base and empties the list
		'{ROW_REQ, CMD_ALLOC, 32'hFFFF_FFFE, 32'd0, 32'd0, 1, 1'b1, 32'hFFFF_FFFF, ST_OK},
		// fill the list to the brim
		'{ROW_REQ, CMD_FREE, 32'd16, 32'h0000_1000, 32'h100, LIST_DEPTH, 1'b1, 32'd0, ST_OK},
		'{ROW_REQ, CMD_FREE, 32'hFFFF_FFFF, 32'd0, 32'd0, 1, 1'b1, 32'd0, ST_FULL},
		// too small wins over list full
		'{ROW_REQ, CMD_FREE, 32'd15, 32'd0, 32'd0, 1, 1'b1, 32'd0, ST_TOO_SMALL},
		// zero-byte split off the head
		'{ROW_REQ, CMD_ALLOC, 32'd0, 32'd0, 32'd0, 1, 1'b0, 32'd0, ST_OK},
		'{ROW_REQ, CMD_ALLOC, 32'd16, 32'd0, 32'd0, 1, 1'b1, 32'h0000_1F00, ST_OK},
		// minimum of zero: empty blocks are kept and matched exactly
		'{ROW_MIN, CMD_ALLOC, 32'd0, 32'd0, 32'd0, 0, 1'b0, 32'd0, ST_OK},
		'{ROW_REQ, CMD_FREE, 32'd0, 32'h0000_55AA, 32'd0, 1, 1'b1, 32'd0, ST_OK},
		'{ROW_REQ, CMD_ALLOC, 32'd0, 32'd0, 32'd0, 1, 1'b1, 32'h0000_55AA, ST_OK},
		// large minimum, above any random pick
		'{ROW_MIN, CMD_ALLOC, 32'd4096, 32'd0, 32'd0, 0, 1'b0, 32'd0, ST_OK},
		'{ROW_REQ, CMD_FREE, 32'd4096, 32'h8000_0000, 32'd0, 1, 1'b1, 32'd0, ST_OK},
		'{ROW_REQ, CMD_ALLOC, 32'd4096, 32'd0, 32'd0, 1, 1'b1, 32'h8000_0000, ST_OK},
		// smallest nonzero minimum, split leaving a one-byte block
		'{ROW_MIN, CMD_ALLOC, 32'd1, 32'd0, 32'd0, 0, 1'b0, 32'd0, ST_OK},
		'{ROW_REQ, CMD_ALLOC, 32'd15, 32'd0, 32'd0, 1, 1'b0, 32'd0, ST_OK}
	};

	// minimum per random phase, negative picks a random legal value
	int phase_min [PHASES] = '{16, 1, 4096, -1, 0, -1};

	function automatic void log_mismatch(string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("mismatch at %0t: %s", $time, msg);
		end
	endfunction

	// apply one request to the shadow list and return what the block must answer
	function automatic resp_t alloc_outcome(req_t r);
		resp_t       o;
		logic [32:0] need;
		int          hit;
		bit          exact;

		o.result_addr = '0;
		o.status      = ST_NO_FIT;
		hit           = -1;
		exact         = 1'b0;
		if (r.cmd == CMD_FREE) begin
			if (r.req_size < DATA_W'(shadow_min)) begin
				o.status = ST_TOO_SMALL;
			end else if (shadow_count >= LIST_DEPTH) begin
				o.status = ST_FULL;
			end else begin
				// push at the head, everything else moves down one
				for (int k = shadow_count; k > 0; k--) begin
					shadow_base[k] = shadow_base[k-1];
					shadow_size[k] = shadow_size[k-1];
				end
				shadow_base[0] = r.block_addr;
				shadow_size[0] = r.req_size;
				shadow_count++;
				o.status = ST_OK;
			end
		end else begin
			need = {1'b0, r.req_size} + 33'(shadow_min);
			// first entry that either matches exactly or leaves enough behind
			for (int k = 0; k < shadow_count; k++) begin
				if (hit < 0 && shadow_size[k] == r.req_size) begin
					hit   = k;
					exact = 1'b1;
				end else if (hit < 0 && {1'b0, shadow_size[k]} >= need) begin
					hit = k;
				end
			end
			if (hit >= 0 && exact) begin
				o.result_addr = shadow_base[hit];
				for (int k = hit; k + 1 < shadow_count; k++) begin
					shadow_base[k] = shadow_base[k+1];
					shadow_size[k] = shadow_size[k+1];
				end
				shadow_count--;
				o.status = ST_OK;
			end else if (hit >= 0) begin
				// shrink and hand out the tail, wrapping in 32 bits
				shadow_size[hit] = shadow_size[hit] - r.req_size;
				o.result_addr    = shadow_base[hit] + shadow_size[hit];
				o.status         = ST_OK;
			end
		end
		return o;
	endfunction

	// request and response watcher, sampling pre-edge values at every rising edge
	always @(posedge clk) begin
		resp_t   want;
		pinned_t pin;

		if (req_valid && !req_stall) begin
			want = alloc_outcome(req_data);
			if (pinned_q.size() != 0) begin
				pin = pinned_q.pop_front();
				if (pin.on) begin
					want = pin.resp;
				end
			end
			alloc_results_q.push_back(want);
		end
		if (resp_valid && !resp_stall) begin
			if (alloc_results_q.size() == 0) begin
				log_mismatch($sformatf("result %h/%s with nothing outstanding",
					resp_data.result_addr, resp_data.status.name()));
			end else begin
				want = alloc_results_q.pop_front();
				if (resp_data.result_addr !== want.result_addr ||
						resp_data.status !== want.status) begin
					log_mismatch($sformatf("result_addr exp %h got %h, status exp %s got %s",
						want.result_addr, resp_data.result_addr,
						want.status.name(), resp_data.status.name()));
				end
			end
		end
	end

	// receiver: stall pattern changes mode after each run of random length,
	// a hold-off ask from the sender stalls it solid for a long stretch
	initial begin
		int mode;
		int run;
		int tick;
		int hold_seen;
		int hold_left;

		tick      = 0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			mode = $urandom_range(0, 3);
			run  = $urandom_range(4, 60);
			repeat (run) begin
				@(posedge clk);
				tick++;
				if (hold_asks != hold_seen) begin
					hold_seen = hold_asks;
					hold_left = LONG_HOLD;
				end
				if (hold_left > 0) begin
					hold_left--;
					resp_stall <= 1'b1;
				end else begin
					case (mode)
						0: resp_stall <= 1'b0;
						1: resp_stall <= ($urandom_range(0, 3) == 0);
						2: resp_stall <= ($urandom_range(0, 4) != 0);
						default: resp_stall <= ((tick % 5) < 2);
					endcase
				end
			end
		end
	end

	// offer one request and hold it until taken; returns at the accepting edge
	task automatic send_item(input req_t r, input bit pin_on, input resp_t pin_resp);
		pinned_t pin;

		pin.on   = pin_on;
		pin.resp = pin_resp;
		pinned_q.push_back(pin);
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
	endtask

	// sender stops and waits until every result owed has come back
	task automatic drain_results();
		req_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (alloc_results_q.size() != 0);
	endtask

	// write min_block_bytes while the block is idle, then read it back
	task automatic write_min_block(input logic [MIN_W-1:0] value);
		drain_results();
		// the block is already idle once its last result is back; the wait only adds margin
		repeat (LIST_DEPTH + 4) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MIN_BLOCK_ADDR;
		pwdata  <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		shadow_min = value;
		// straight into the setup cycle of the read
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		if (prdata !== DATA_W'(value)) begin
			log_mismatch($sformatf("min_block_bytes read exp %h got %h",
				DATA_W'(value), prdata));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [DATA_W-1:0] recent_size();
		return recent_sizes[$urandom_range(0, RECENT_DEPTH - 1)];
	endfunction

	// random free: mostly keepable sizes, some too small, some huge
	function automatic req_t random_free();
		req_t r;
		int   pick;

		r.cmd        = CMD_FREE;
		r.block_addr = $urandom;
		pick         = $urandom_range(0, 99);
		if (pick < 65) begin
			r.req_size = DATA_W'(shadow_min) + $urandom_range(0, 3 * int'(shadow_min) + 8);
		end else if (pick < 75) begin
			r.req_size = $urandom;
		end else if (pick < 85) begin
			r.req_size = (shadow_min == 0) ? '0 : $urandom_range(0, int'(shadow_min) - 1);
		end else begin
			r.req_size = recent_size();
		end
		if (r.req_size >= DATA_W'(shadow_min)) begin
			recent_sizes[recent_wr] = r.req_size;
			recent_wr = (recent_wr + 1) % RECENT_DEPTH;
		end
		return r;
	endfunction

	// random allocate: aimed at exact hits and splits of recent sizes, plus noise
	function automatic req_t random_alloc();
		req_t              r;
		int                pick;
		logic [DATA_W-1:0] base;

		r.cmd        = CMD_ALLOC;
		r.block_addr = $urandom;
		pick         = $urandom_range(0, 99);
		base         = recent_size();
		if (pick < 35) begin
			r.req_size = base;
		end else if (pick < 60) begin
			if (base > DATA_W'(shadow_min) + 8) begin
				r.req_size = base - DATA_W'(shadow_min) - $urandom_range(0, 8);
			end else begin
				r.req_size = $urandom_range(0, 8);
			end
		end else if (pick < 75) begin
			r.req_size = $urandom_range(0, 2 * int'(shadow_min) + 4);
		end else if (pick < 85) begin
			r.req_size = $urandom;
		end else if (pick < 95) begin
			r.req_size = '0;
		end else begin
			r.req_size = '1;
		end
		return r;
	endfunction

	// main sequence
	initial begin
		req_t  r;
		resp_t pin_resp;
		int    sent;
		int    burst;
		int    gap;
		int    free_pct;
		int    min_val;

		for (int k = 0; k < RECENT_DEPTH; k++) begin
			recent_sizes[k] = 32'd16;
		end

		// reset held from time zero, released on a rising edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_MIN) begin
				write_min_block(dir_rows[i].size[MIN_W-1:0]);
			end else begin
				for (int n = 0; n < dir_rows[i].reps; n++) begin
					r.cmd                = dir_rows[i].cmd;
					r.req_size           = dir_rows[i].size;
					r.block_addr         = dir_rows[i].addr + n * dir_rows[i].step;
					pin_resp.result_addr = dir_rows[i].want_addr;
					pin_resp.status      = dir_rows[i].want_status;
					send_item(r, dir_rows[i].pinned, pin_resp);
				end
			end
		end

		// random phases, each under its own minimum
		pin_resp = '0;
		for (int ph = 0; ph < PHASES; ph++) begin
			min_val = (phase_min[ph] < 0) ? $urandom_range(2, 4095) : phase_min[ph];
			write_min_block(MIN_W'(min_val));
			// once, let the receiver sit while requests keep coming so the input backs up
			if (ph == 1) begin
				hold_asks++;
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst    = $urandom_range(1, 24);
				free_pct = $urandom_range(25, 75);
				while (burst > 0 && sent < PHASE_ITEMS) begin
					if ($urandom_range(0, 99) < free_pct) begin
						r = random_free();
					end else begin
						r = random_alloc();
					end
					send_item(r, 1'b0, pin_resp);
					burst--;
					sent++;
				end
				// now and then the sender pauses until everything is back
				if ($urandom_range(0, 40) == 0) begin
					drain_results();
				end else if ($urandom_range(0, 3) != 0) begin
					gap = $urandom_range(1, 10);
					req_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		drain_results();
		repeat (LIST_DEPTH + 8) @(posedge clk);
		if (mismatches == 0 && alloc_results_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// watchdog that ends a hung run
	initial begin
		#5000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: filelist.f
sv/ffa_pkg.sv
sv/ffa_cell.sv
sv/first_fit_free_list_allocator.sv
dv/first_fit_free_list_allocator_test.sv
